[src/bsf_pkg.sv]
// Shared types and constants for the bounding sphere fit block.
package bsf_pkg;

  localparam int CoordW = 24;
  localparam int RadW   = CoordW + 1;
  localparam int DiffW  = CoordW + 2;
  localparam int SqW    = 2 * DiffW + 2;
  localparam int PassW  = 3;
  localparam int TolW   = 8;

  localparam logic [1:0] RegPasses = 2'd0;
  localparam logic [1:0] RegTol    = 2'd1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [RadW-1:0] rad_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    rad_t   sphere_radius;
    logic   overflowed;
  } result_t;

  typedef struct packed {
    point_t point;
    logic   last_point;
  } request_t;

endpackage

[src/bsf_if.sv]
// Valid/ready channel carrying one payload.
interface bsf_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/bounding_sphere_fit_top.sv]
// Sequence: the last point starts up to P+1 scans of the N stored points, each
// followed by a square root; each pass that moves the centre reads the far point
// and runs one divide per axis, then the result is registered (P = refine_passes).
// Throughput: one point per cycle while loading; a new set loads while a result waits.
// Reset: synchronous active-low; clears count, drop flag, control and
// output valid; registers return to refine_passes 3, grow_tolerance 0.
module bounding_sphere_fit_top #(
  parameter int MAX_TRIANGLES = 128
) (
  input  logic clk,
  input  logic rst_n,
  bsf_if.sink   in_ch,
  bsf_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import bsf_pkg::*;

  localparam int Cap  = 3 * MAX_TRIANGLES;
  localparam int AW   = $clog2(Cap);
  localparam int CntW = $clog2(Cap + 1);
  localparam int NumW = 2 * DiffW;
  localparam int DenW = RadW + 2;

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN, S_SQRT, S_SQWAIT, S_CHECK, S_FAR, S_DIV, S_DIVWAIT,
    S_APPLY, S_OUT
  } state_t;

  state_t state_r;
  logic [PassW-1:0] passes_r;
  logic [TolW-1:0] tol_r;
  logic [CntW-1:0] count_r;
  logic drop_r;
  point_t lo_r, hi_r;
  coord_t cx_r, cy_r, cz_r;
  rad_t r_r, d_r;
  logic [SqW-1:0] best_r;
  logic [AW-1:0] far_r;
  logic [CntW-1:0] idx_r;
  logic rvalid_r;
  logic [AW-1:0] rd_idx_r;
  logic [PassW-1:0] pass_r;
  logic first_r;
  logic [1:0] axis_r;
  point_t farp_r;
  logic [NumW-1:0] num_r;
  logic neg_r;
  result_t res_r;
  logic ovalid_r;

  logic we;
  logic [AW-1:0] raddr;
  point_t rdata;
  logic sq_start, sq_busy, dv_start, dv_busy;
  logic [SqW/2-1:0] sq_root;
  logic [NumW-1:0] quo;
  logic [DiffW-1:0] dx, dy, dz;
  logic [SqW-1:0] d2;
  logic [DiffW-1:0] pk, ck;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0] adiff;
  logic [RadW+1:0] rt;

  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[2])
      RegPasses[0]: cfg_prdata = 32'(passes_r);
      default:      cfg_prdata = 32'(tol_r);
    endcase
  end

  assign in_ch.ready = (state_r == S_LOAD);
  assign we = in_ch.valid && in_ch.ready && (count_r < CntW'(Cap));
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = res_r;

  bsf_store #(.Depth(Cap)) u_store (
    .clk(clk), .we(we), .waddr(count_r[AW-1:0]), .wdata(in_ch.data.point),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    raddr = idx_r[AW-1:0];
    if (state_r == S_FAR) begin
      raddr = far_r;
    end
  end

  function automatic logic [DiffW-1:0] absdiff(coord_t a, coord_t b);
    logic signed [DiffW-1:0] t;
    t = DiffW'(a) - DiffW'(b);
    return t[DiffW-1] ? DiffW'(-t) : DiffW'(t);
  endfunction

  assign dx = absdiff(rdata.x, cx_r);
  assign dy = absdiff(rdata.y, cy_r);
  assign dz = absdiff(rdata.z, cz_r);
  assign d2 = SqW'(dx) * SqW'(dx) + SqW'(dy) * SqW'(dy) + SqW'(dz) * SqW'(dz);

  assign sq_start = (state_r == S_SQRT);
  bsf_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .value(best_r),
    .busy(sq_busy), .root(sq_root)
  );

  always_comb begin
    case (axis_r)
      2'd0:    begin pk = DiffW'(farp_r.x); ck = DiffW'(cx_r); end
      2'd1:    begin pk = DiffW'(farp_r.y); ck = DiffW'(cy_r); end
      default: begin pk = DiffW'(farp_r.z); ck = DiffW'(cz_r); end
    endcase
    diff = pk - ck;
    adiff = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  end

  assign dv_start = (state_r == S_DIV);
  bsf_divider #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(num_r),
    .den({1'b0, d_r, 1'b0}), .busy(dv_busy), .quo(quo)
  );

  assign rt = (RadW+2)'(r_r) + (RadW+2)'(tol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      passes_r <= 3'd3;
      tol_r <= '0;
      count_r <= '0;
      drop_r <= 1'b0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[2])
          RegPasses[0]: passes_r <= cfg_pwdata[PassW-1:0];
          default:      tol_r <= cfg_pwdata[TolW-1:0];
        endcase
      end
      if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_ch.valid && in_ch.ready) begin
            if (we) begin
              count_r <= count_r + 1'b1;
              if (count_r == '0 || in_ch.data.point.x < lo_r.x) lo_r.x <= in_ch.data.point.x;
              if (count_r == '0 || in_ch.data.point.y < lo_r.y) lo_r.y <= in_ch.data.point.y;
              if (count_r == '0 || in_ch.data.point.z < lo_r.z) lo_r.z <= in_ch.data.point.z;
              if (count_r == '0 || in_ch.data.point.x > hi_r.x) hi_r.x <= in_ch.data.point.x;
              if (count_r == '0 || in_ch.data.point.y > hi_r.y) hi_r.y <= in_ch.data.point.y;
              if (count_r == '0 || in_ch.data.point.z > hi_r.z) hi_r.z <= in_ch.data.point.z;
            end else begin
              drop_r <= 1'b1;
            end
            if (in_ch.data.last_point) begin
              state_r <= S_CHECK;
              first_r <= 1'b1;
              pass_r <= '0;
            end
          end
        end
        S_CHECK: begin
          if (first_r) begin
            cx_r <= coord_t'(((DiffW)'(lo_r.x) + (DiffW)'(hi_r.x)) >>> 1);
            cy_r <= coord_t'(((DiffW)'(lo_r.y) + (DiffW)'(hi_r.y)) >>> 1);
            cz_r <= coord_t'(((DiffW)'(lo_r.z) + (DiffW)'(hi_r.z)) >>> 1);
            idx_r <= '0;
            best_r <= '0;
            far_r <= '0;
            rvalid_r <= 1'b0;
            state_r <= S_SCAN;
          end else if (pass_r == passes_r) begin
            state_r <= S_OUT;
          end else begin
            idx_r <= '0;
            best_r <= '0;
            far_r <= '0;
            rvalid_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          rvalid_r <= (idx_r < count_r);
          rd_idx_r <= idx_r[AW-1:0];
          if (idx_r < count_r) begin
            idx_r <= idx_r + 1'b1;
          end
          if (rvalid_r && d2 > best_r) begin
            best_r <= d2;
            far_r <= rd_idx_r;
          end
          if (!rvalid_r && idx_r == count_r) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: state_r <= S_SQWAIT;
        S_SQWAIT: begin
          if (!sq_busy) begin
            if (first_r) begin
              r_r <= rad_t'(sq_root);
              first_r <= 1'b0;
              state_r <= S_CHECK;
            end else begin
              d_r <= rad_t'(sq_root);
              if ((RadW+2)'(sq_root) <= rt) begin
                state_r <= S_OUT;
              end else begin
                state_r <= S_FAR;
                axis_r <= 2'd0;
                rvalid_r <= 1'b0;
              end
            end
          end
        end
        S_FAR: begin
          rvalid_r <= 1'b1;
          if (rvalid_r) begin
            farp_r <= rdata;
            state_r <= S_APPLY;
            axis_r <= 2'd0;
          end
        end
        S_APPLY: begin
          num_r <= NumW'(adiff) * NumW'(d_r - r_r);
          neg_r <= diff[DiffW-1];
          state_r <= S_DIV;
        end
        S_DIV: state_r <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (!dv_busy) begin
            case (axis_r)
              2'd0: cx_r <= coord_t'(cx_r + (neg_r ? coord_t'(-quo) : coord_t'(quo)));
              2'd1: cy_r <= coord_t'(cy_r + (neg_r ? coord_t'(-quo) : coord_t'(quo)));
              default: cz_r <= coord_t'(cz_r + (neg_r ? coord_t'(-quo) : coord_t'(quo)));
            endcase
            if (axis_r == 2'd2) begin
              r_r <= rad_t'(((RadW+1)'(r_r) + (RadW+1)'(d_r)) >> 1);
              pass_r <= pass_r + 1'b1;
              state_r <= S_CHECK;
            end else begin
              axis_r <= axis_r + 1'b1;
              state_r <= S_APPLY;
            end
          end
        end
        S_OUT: begin
          if (!ovalid_r) begin
            res_r <= '{cx_r, cy_r, cz_r, r_r, drop_r};
            ovalid_r <= 1'b1;
            count_r <= '0;
            drop_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

[src/bsf_isqrt.sv]
// Iterative floor square root; busy stays high until the root is complete, and a start while busy restarts it.
module bsf_isqrt (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [bsf_pkg::SqW-1:0] value,
  output logic busy,
  output logic [bsf_pkg::SqW/2-1:0] root
);
  import bsf_pkg::*;
  localparam int N = SqW / 2;
  localparam int CntW = $clog2(N + 1);

  logic [SqW-1:0] rem_r, rem_nxt;
  logic [N-1:0] res_r, res_nxt;
  logic [SqW-1:0] val_r, val_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [N+1:0] trial;
  logic [N+1:0] rem_top;

  assign busy = (cnt_r != '0);
  assign root = res_r;

  always_comb begin
    rem_nxt = rem_r;
    res_nxt = res_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    rem_top = '0;
    trial = {res_r, 2'b01};
    if (start) begin
      rem_nxt = '0;
      res_nxt = '0;
      val_nxt = value;
      cnt_nxt = CntW'(N);
    end else if (busy) begin
      rem_top = {rem_r[N-1:0], val_r[SqW-1:SqW-2]};
      val_nxt = {val_r[SqW-3:0], 2'b00};
      if (rem_top >= trial) begin
        rem_nxt = SqW'(rem_top - trial);
        res_nxt = {res_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = SqW'(rem_top);
        res_nxt = {res_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    val_r <= val_nxt;
  end
endmodule

[src/bsf_divider.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
module bsf_divider #(
  parameter int NumW = 52,
  parameter int DenW = 27
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic busy,
  output logic [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0] rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DenW:0] sh;

  assign busy = (cnt_r != '0);
  assign quo = q_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    sh = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CntW'(NumW);
    end else if (busy) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end
endmodule

[src/bsf_store.sv]
// Point memory with one write port and one registered read port.
module bsf_store #(
  parameter int Depth = 384
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  bsf_pkg::point_t wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output bsf_pkg::point_t rdata
);
  import bsf_pkg::*;
  point_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/bsf_checker.sv]
// Port-level checks for the bounding sphere fit block, bound to the top level.
module bsf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [24:0] out_radius,
  input logic cfg_pready
);
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_radius))
    else $error("result dropped");
  a_nox: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_radius))
    else $error("unknown radius on valid result");
  a_inhold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before acceptance");
endmodule

bind bounding_sphere_fit_top bsf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_radius(out_ch.data.sphere_radius), .cfg_pready(cfg_pready)
);

[tb/testbench.sv]
// Self-checking testbench for the bounding sphere fit block: directed point sets and random sets.
module testbench;
  import bsf_pkg::*;

  localparam int Capacity = 3 * 128;
  localparam int WatchLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  bsf_if #(request_t) in_ch (clk);
  bsf_if #(result_t) out_ch (clk);

  bounding_sphere_fit_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // predictor state
  logic [2:0] passes_q = 3'd3;
  logic [7:0] tol_q = 8'd0;
  longint pts[Capacity][3];
  int unsigned npts = 0;
  longint box_lo[3], box_hi[3];
  bit dropped = 1'b0;
  result_t sphere_q[$];

  int errors = 0;
  int sent = 0, spheres = 0, sets = 0;
  int idle_in = 0, idle_out = 0;
  int quiet = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned span_sq(int unsigned i, longint cen[3]);
    longint unsigned s;
    longint dd;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      dd = pts[i][k] - cen[k];
      s += longint'(dd * dd);
    end
    return s;
  endfunction

  function automatic void fit_point(request_t rq);
    longint p[3], cen[3], num;
    longint unsigned r, best, d2, d;
    int unsigned far;
    result_t res;
    p[0] = rq.point.x;
    p[1] = rq.point.y;
    p[2] = rq.point.z;
    if (npts < Capacity) begin
      for (int k = 0; k < 3; k++) begin
        pts[npts][k] = p[k];
        if (npts == 0 || p[k] < box_lo[k]) box_lo[k] = p[k];
        if (npts == 0 || p[k] > box_hi[k]) box_hi[k] = p[k];
      end
      npts++;
    end else begin
      dropped = 1'b1;
    end
    if (!rq.last_point) return;
    for (int k = 0; k < 3; k++) begin
      num = box_lo[k] + box_hi[k];
      cen[k] = (num >= 0) ? num / 2 : -((-num + 1) / 2);
    end
    best = 0;
    for (int unsigned i = 0; i < npts; i++) begin
      d2 = span_sq(i, cen);
      if (d2 > best) best = d2;
    end
    r = root_floor(best);
    for (int ps = 0; ps < passes_q; ps++) begin
      far = 0;
      best = 0;
      for (int unsigned i = 0; i < npts; i++) begin
        d2 = span_sq(i, cen);
        if (d2 > best) begin
          best = d2;
          far = i;
        end
      end
      d = root_floor(best);
      if (d <= r + tol_q) break;
      for (int k = 0; k < 3; k++) begin
        num = (pts[far][k] - cen[k]) * longint'(d - r);
        cen[k] += num / longint'(2 * d);
      end
      r = (r + d) / 2;
    end
    res.center_x = cen[0][CoordW-1:0];
    res.center_y = cen[1][CoordW-1:0];
    res.center_z = cen[2][CoordW-1:0];
    res.sphere_radius = r[RadW-1:0];
    res.overflowed = dropped;
    sphere_q.insert(sphere_q.size(), res);
    npts = 0;
    dropped = 1'b0;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH sphere %0d %s: got %h want %h", spheres, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("watchdog: nothing accepted for %0d cycles", WatchLimit);
        $display("bounding_sphere_fit_top regression: fail");
        $finish;
      end
      out_ch.ready <= ($urandom_range(99) >= idle_out);
      if (out_ch.valid && out_ch.ready) begin
        if (sphere_q.size() == 0) begin
          report("unexpected sphere", 0, 0);
        end else begin
          result_t w;
          w = sphere_q.pop_front();
          if (out_ch.data.center_x !== w.center_x)
            report("center_x", out_ch.data.center_x, w.center_x);
          if (out_ch.data.center_y !== w.center_y)
            report("center_y", out_ch.data.center_y, w.center_y);
          if (out_ch.data.center_z !== w.center_z)
            report("center_z", out_ch.data.center_z, w.center_z);
          if (out_ch.data.sphere_radius !== w.sphere_radius)
            report("sphere_radius", out_ch.data.sphere_radius, w.sphere_radius);
          if (out_ch.data.overflowed !== w.overflowed)
            report("overflowed", out_ch.data.overflowed, w.overflowed);
        end
        spheres++;
      end
    end
  end

  task automatic send_point(coord_t x, coord_t y, coord_t z, bit last);
    request_t rq;
    int gap;
    rq.point.x = x;
    rq.point.y = y;
    rq.point.z = z;
    rq.last_point = last;
    gap = 0;
    while ($urandom_range(99) < idle_in) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fit_point(rq);
    sent++;
    if (last) sets++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sphere_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx[0], 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == RegPasses) passes_q = val[2:0];
    else tol_q = val[7:0];
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(4000)) - 2000);
      default: return coord_t'($urandom_range(1) ? 24'h7FFFFF : 24'h800000);
    endcase
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  task automatic test_directed();
    send_point(24'sd5, -24'sd7, 24'sd100, 1'b1);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_point(24'h800000, 24'h7FFFFF, 24'sd0, 1'b0);
    send_point(24'h7FFFFF, 24'h800000, -24'sd1, 1'b0);
    send_point(24'sd0, 24'sd0, 24'sd0, 1'b1);
    send_point(-24'sd1, -24'sd2, -24'sd3, 1'b0);
    send_point(24'sd300, 24'sd10, -24'sd50, 1'b0);
    send_point(24'sd1, 24'sd900, 24'sd4, 1'b0);
    send_point(24'sd1, 24'sd900, 24'sd4, 1'b1);
  endtask

  task automatic test_overflow();
    // fill past capacity, last point dropped too
    for (int i = 0; i < Capacity + 3; i++)
      send_point(rand_coord(1), rand_coord(1), rand_coord(1), i == Capacity + 2);
    // exactly full, then a fresh set proves the flag cleared
    send_set(Capacity, 1);
    send_set(3, 1);
  endtask

  task automatic test_random(int count);
    int goal;
    goal = sent + count;
    while (sent < goal) begin
      int n;
      n = ($urandom_range(40) == 0) ? $urandom_range(Capacity + 4, 100)
                                    : $urandom_range(12, 1);
      send_set(n, $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_in = 35;
    idle_out = 65;
    test_directed();
    drain();
    write_reg(RegPasses, 32'd0);
    write_reg(RegTol, 32'd255);
    test_directed();
    test_random(100);
    drain();
    write_reg(RegPasses, 32'd7);
    write_reg(RegTol, 32'd0);
    test_overflow();
    idle_in = 65;
    idle_out = 35;
    test_random(330);
    drain();
    write_reg(RegPasses, 32'd1);
    write_reg(RegTol, 32'd3);
    test_random(240);
    drain();
    write_reg(RegPasses, 32'd5);
    write_reg(RegTol, 32'd40);
    idle_in = 0;
    idle_out = 0;
    test_random(300);
    drain();
    write_reg(RegPasses, 32'd3);
    write_reg(RegTol, 32'd0);
    test_random(80);
    drain();
    $display("covered %0d points in %0d sets, %0d spheres checked", sent, sets, spheres);
    $display("pass limits 0..7, tolerance 0..255, store overflow and idle mixes");
    if (errors == 0 && sphere_q.size() == 0) begin
      $display("bounding_sphere_fit_top regression: pass");
    end else begin
      $display("bounding_sphere_fit_top regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
src/bsf_pkg.sv
src/bsf_if.sv
src/bsf_isqrt.sv
src/bsf_divider.sv
src/bsf_store.sv
src/bounding_sphere_fit_top.sv
src/bsf_checker.sv
tb/testbench.sv
